### design/hsmp_pkg.sv
package hsmp_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int FILL_W       = $clog2(HEADER_BYTES + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_USER_W  = 2;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_USER_W = 5;
  localparam int OUT_DATA_W = 88;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_THIRD     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SUM       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_CAPACITY = 3'd4;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_START = 2'd1,
    CMD_RESET = 2'd2,
    CMD_BAD   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_NEED_MORE   = 3'd0,
    ST_PARSED      = 3'd1,
    ST_TOO_SMALL   = 3'd2,
    ST_WRONG_STATE = 3'd3,
    ST_CMD_DONE    = 3'd4
  } status_e;

  typedef struct packed {
    logic [7:0]  magic_first;
    logic [7:0]  magic_second;
    logic [7:0]  magic_third;
    logic [7:0]  magic_sum;
    logic [15:0] buffer_capacity;
  } cfg_t;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic        header_valid;
    logic [15:0] payload_length;
    logic [15:0] reset_value;
    logic [15:0] sequence_number;
    logic [15:0] opcode_value;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_position;
  } result_t;

endpackage

### design/hsmp_front.sv
module hsmp_front #(
  parameter int DEPTH = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [hsmp_pkg::IN_USER_W-1:0]      in_user_i,
  input  logic [hsmp_pkg::IN_DATA_W-1:0]      in_data_i,
  output logic                                item_valid_o,
  input  logic                                item_ready_i,
  output hsmp_pkg::item_t                     item_o
);
  import hsmp_pkg::*;

  // depth of at least two
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;
  item_t            in_item;

  // classify the command code at the door
  assign in_item.cmd  = cmd_e'(in_user_i);
  assign in_item.data = in_data_i;

  assign in_ready_o   = (count_q != CNT_FULL);
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count did not grow on push");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push && !pop) |=> $stable(count_q) && $stable(rd_ptr_q))
    else $error("queue moved without a transfer");

endmodule

### design/hsmp_back.sv
module hsmp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hsmp_pkg::cfg_t    cfg_i,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  hsmp_pkg::item_t   item_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output hsmp_pkg::result_t res_o
);
  import hsmp_pkg::*;

  localparam logic PHASE_SEEK    = 1'b0;
  localparam logic PHASE_COLLECT = 1'b1;

  localparam logic [1:0] MSG_BUSY      = 2'd0;
  localparam logic [1:0] MSG_DONE      = 2'd1;
  localparam logic [1:0] MSG_TOO_SMALL = 2'd2;

  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HEADER_BYTES);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(HEADER_BYTES - 1);

  logic [7:0]        win_q    [HEADER_BYTES];
  logic [7:0]        win_next [HEADER_BYTES];
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              phase_q, phase_d;
  logic [15:0]       exp_len_q, exp_len_d;
  logic [15:0]       count_q, count_d;
  logic [1:0]        msg_q, msg_d;
  logic              win_shift;
  logic              take;
  logic              out_valid_q;
  result_t           res_q, res_d;
  logic [7:0]        psum;
  logic              magic_ok, parity_ok;
  logic [15:0]       count_inc, hdr_len;

  assign item_ready_o = !out_valid_q || res_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign res_valid_o  = out_valid_q;
  assign res_o        = res_q;

  // window as it stands after this byte shifts in
  always_comb begin
    for (int i = 0; i < HEADER_BYTES - 1; i++) begin
      win_next[i] = win_q[i + 1];
    end
    win_next[HEADER_BYTES-1] = item_i.data;
  end

  always_comb begin
    psum = cfg_i.magic_sum;
    for (int k = 4; k < HEADER_BYTES; k++) begin
      psum = psum + win_next[k];
    end
  end

  assign magic_ok  = (win_next[0] == cfg_i.magic_first) &&
                     (win_next[1] == cfg_i.magic_second) &&
                     (win_next[2] == cfg_i.magic_third);
  assign parity_ok = (~psum == win_next[3]);
  assign hdr_len   = {win_next[5], win_next[4]};
  assign count_inc = count_q + 16'd1;

  always_comb begin
    fill_d    = fill_q;
    phase_d   = phase_q;
    exp_len_d = exp_len_q;
    count_d   = count_q;
    msg_d     = msg_q;
    win_shift = 1'b0;
    res_d     = '0;
    res_d.status = ST_NEED_MORE;
    case (item_i.cmd)
      CMD_START, CMD_RESET: begin
        if (item_i.cmd == CMD_RESET) begin
          fill_d    = '0;
          phase_d   = PHASE_SEEK;
          exp_len_d = '0;
        end
        if (cfg_i.buffer_capacity == '0) begin
          res_d.status = ST_WRONG_STATE;
        end else begin
          msg_d        = MSG_BUSY;
          count_d      = '0;
          res_d.status = ST_CMD_DONE;
        end
      end
      CMD_DATA: begin
        if (msg_q != MSG_BUSY) begin
          res_d.status = ST_WRONG_STATE;
        end else if (phase_q == PHASE_COLLECT) begin
          res_d.payload_valid    = 1'b1;
          res_d.payload_byte     = item_i.data;
          res_d.payload_position = count_q;
          count_d                = count_inc;
          if (count_inc == exp_len_q) begin
            phase_d      = PHASE_SEEK;
            exp_len_d    = '0;
            msg_d        = MSG_DONE;
            res_d.status = ST_PARSED;
          end
        end else begin
          win_shift = 1'b1;
          fill_d    = (fill_q == FILL_FULL) ? FILL_FULL : fill_q + 1'b1;
          // window is full once this byte is in
          if (fill_q >= FILL_LAST && magic_ok && parity_ok) begin
            res_d.header_valid    = 1'b1;
            res_d.payload_length  = hdr_len;
            res_d.reset_value     = {win_next[7], win_next[6]};
            res_d.sequence_number = {win_next[9], win_next[8]};
            res_d.opcode_value    = {win_next[11], win_next[10]};
            fill_d    = '0;
            exp_len_d = hdr_len;
            if (hdr_len == '0) begin
              msg_d        = MSG_DONE;
              res_d.status = ST_PARSED;
            end else begin
              phase_d = PHASE_COLLECT;
              if (hdr_len > cfg_i.buffer_capacity) begin
                msg_d        = MSG_TOO_SMALL;
                res_d.status = ST_TOO_SMALL;
              end
            end
          end
        end
      end
      default: begin
        res_d.status = ST_WRONG_STATE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      phase_q     <= PHASE_SEEK;
      exp_len_q   <= '0;
      count_q     <= '0;
      msg_q       <= MSG_BUSY;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        fill_q      <= fill_d;
        phase_q     <= phase_d;
        exp_len_q   <= exp_len_d;
        count_q     <= count_d;
        msg_q       <= msg_d;
        out_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // window contents only count once the fill reaches the full header
  always_ff @(posedge clk_i) begin
    if (take && win_shift) begin
      for (int i = 0; i < HEADER_BYTES; i++) begin
        win_q[i] <= win_next[i];
      end
    end
    if (take) begin
      res_q <= res_d;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("window fill beyond header size");

  a_phase_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PHASE_SEEK) == (exp_len_q == '0))
    else $error("expected length out of step with phase");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.header_valid && res_q.payload_valid))
    else $error("result flags both header and payload");

endmodule

### design/header_sync_message_parser.sv
// header sync message parser
// input stream s_axis: one transfer per received byte or command; tuser holds the
// command (data byte, start new message, full parser reset), tdata the byte.
// output stream m_axis: exactly one result transfer per input transfer, in order;
// tuser flags the status and whether a header or a payload byte is reported,
// tdata carries the header fields and the payload byte with its position.
// configuration: cfg_we_i writes register cfg_idx_i (magic bytes, parity seed,
// buffer capacity) from cfg_data_i; write only while the stream is idle.
// an input is stored in the input queue, then its result in the result register.
// throughput: one item per cycle unless stalled; the parser updates its window,
// counters and message state at once; consecutive bytes never wait on each other.
// a small input queue sits in front of the parser and a result register behind it.
// when m_axis_tready is low the result register holds, the parser stops, the
// queue fills and s_axis_tready drops once it is full.
// reset: queue and result register empty, parser seeking a header with an empty
// window, registers at their defaults (magic bytes zero, capacity 65535).
module header_sync_message_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [hsmp_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hsmp_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [1:0] command
  input  logic [hsmp_pkg::IN_USER_W-1:0]       s_axis_tuser,
  // [7:0] byte_in
  input  logic [hsmp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [2:0] status, [3] header_valid, [4] payload_valid
  output logic [hsmp_pkg::OUT_USER_W-1:0]      m_axis_tuser,
  // [15:0] payload_length, [31:16] reset_value, [47:32] sequence_number,
  // [63:48] opcode_value, [71:64] payload_byte, [87:72] payload_position
  output logic [hsmp_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
  import hsmp_pkg::*;

  cfg_t    cfg_q;
  item_t   item;
  logic    item_valid, item_ready;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_first     <= '0;
      cfg_q.magic_second    <= '0;
      cfg_q.magic_third     <= '0;
      cfg_q.magic_sum       <= '0;
      cfg_q.buffer_capacity <= 16'hFFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAGIC_FIRST:     cfg_q.magic_first     <= cfg_data_i[7:0];
        REG_MAGIC_SECOND:    cfg_q.magic_second    <= cfg_data_i[7:0];
        REG_MAGIC_THIRD:     cfg_q.magic_third     <= cfg_data_i[7:0];
        REG_MAGIC_SUM:       cfg_q.magic_sum       <= cfg_data_i[7:0];
        REG_BUFFER_CAPACITY: cfg_q.buffer_capacity <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  hsmp_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_user_i    (s_axis_tuser),
    .in_data_i    (s_axis_tdata),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  hsmp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tuser = {res.payload_valid, res.header_valid, res.status};
  assign m_axis_tdata = {res.payload_position, res.payload_byte, res.opcode_value,
                         res.sequence_number, res.reset_value, res.payload_length};

endmodule

### bench/tb_parse_pkg.sv
`timescale 1ns / 100ps

package tb_parse_pkg;
  import hsmp_pkg::*;

  // message state of the parser
  localparam logic [1:0] MSG_OPEN     = 2'd0;
  localparam logic [1:0] MSG_DONE     = 2'd1;
  localparam logic [1:0] MSG_OVERSIZE = 2'd2;

  class header_parse_scoreboard;
    cfg_t        regs;
    logic [7:0]  window [HEADER_BYTES];
    int unsigned fill;
    bit          in_payload;
    logic [15:0] want_len;
    logic [15:0] byte_count;
    logic [1:0]  msg_state;
    result_t     expected_results [$];
    int unsigned n_errors;
    int unsigned useful_items;

    function new();
      regs.magic_first     = '0;
      regs.magic_second    = '0;
      regs.magic_third     = '0;
      regs.magic_sum       = '0;
      regs.buffer_capacity = 16'hFFFF;
      clear_window();
      in_payload   = 1'b0;
      want_len     = '0;
      byte_count   = '0;
      msg_state    = MSG_OPEN;
      n_errors     = 0;
      useful_items = 0;
    endfunction

    function void clear_window();
      foreach (window[i]) window[i] = '0;
      fill = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_MAGIC_FIRST:     regs.magic_first     = val[7:0];
        REG_MAGIC_SECOND:    regs.magic_second    = val[7:0];
        REG_MAGIC_THIRD:     regs.magic_third     = val[7:0];
        REG_MAGIC_SUM:       regs.magic_sum       = val[7:0];
        REG_BUFFER_CAPACITY: regs.buffer_capacity = val;
        default: ;
      endcase
    endfunction

    // zero capacity leaves the message part untouched
    function status_e open_message();
      if (regs.buffer_capacity == 16'd0) return ST_WRONG_STATE;
      msg_state  = MSG_OPEN;
      byte_count = '0;
      return ST_CMD_DONE;
    endfunction

    function result_t predict_parse(item_t it);
      result_t    r;
      logic [7:0] parity;
      r = '0;
      r.status = ST_NEED_MORE;
      case (it.cmd)
        CMD_START: begin
          r.status = open_message();
          return r;
        end
        CMD_RESET: begin
          clear_window();
          in_payload = 1'b0;
          want_len   = '0;
          r.status   = open_message();
          return r;
        end
        CMD_BAD: begin
          r.status = ST_WRONG_STATE;
          return r;
        end
        default: ;
      endcase
      if (msg_state != MSG_OPEN) begin
        r.status = ST_WRONG_STATE;
        return r;
      end
      if (in_payload) begin
        r.payload_valid    = 1'b1;
        r.payload_byte     = it.data;
        r.payload_position = byte_count;
        byte_count++;
        if (byte_count == want_len) begin
          in_payload = 1'b0;
          want_len   = '0;
          msg_state  = MSG_DONE;
          r.status   = ST_PARSED;
        end
        return r;
      end
      if (fill < HEADER_BYTES) begin
        window[fill] = it.data;
        fill++;
      end else begin
        for (int i = 0; i < HEADER_BYTES - 1; i++) window[i] = window[i+1];
        window[HEADER_BYTES-1] = it.data;
      end
      if (fill < HEADER_BYTES) return r;
      if (window[0] != regs.magic_first || window[1] != regs.magic_second ||
          window[2] != regs.magic_third) return r;
      parity = regs.magic_sum;
      for (int k = 4; k < HEADER_BYTES; k++) parity += window[k];
      parity = ~parity;
      if (parity != window[3]) return r;
      r.header_valid    = 1'b1;
      r.payload_length  = {window[5], window[4]};
      r.reset_value     = {window[7], window[6]};
      r.sequence_number = {window[9], window[8]};
      r.opcode_value    = {window[11], window[10]};
      want_len = r.payload_length;
      clear_window();
      if (want_len == 16'd0) begin
        msg_state = MSG_DONE;
        r.status  = ST_PARSED;
      end else begin
        // an oversized payload still enters collection but the message is flagged
        in_payload = 1'b1;
        if (want_len > regs.buffer_capacity) begin
          msg_state = MSG_OVERSIZE;
          r.status  = ST_TOO_SMALL;
        end
      end
      return r;
    endfunction

    function void note_input(item_t it);
      result_t r;
      r = predict_parse(it);
      if (r.status != ST_WRONG_STATE) useful_items++;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        n_errors++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d", got.status);
        n_errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("header_valid", want.header_valid, got.header_valid);
      compare_field("payload_length", want.payload_length, got.payload_length);
      compare_field("reset_value", want.reset_value, got.reset_value);
      compare_field("sequence_number", want.sequence_number, got.sequence_number);
      compare_field("opcode_value", want.opcode_value, got.opcode_value);
      compare_field("payload_valid", want.payload_valid, got.payload_valid);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_position", want.payload_position, got.payload_position);
    endfunction
  endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import hsmp_pkg::*;
  import tb_parse_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int ITEM_TARGET = 1600;
  localparam int PHASE_ITEMS = 220;

  logic                     clk_i;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_IDX_W-1:0]     cfg_idx;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     s_valid;
  logic                     s_axis_tready;
  logic [IN_USER_W-1:0]     s_user;
  logic [IN_DATA_W-1:0]     s_data;
  logic                     m_axis_tvalid;
  logic                     m_ready;
  logic [OUT_USER_W-1:0]    m_axis_tuser;
  logic [OUT_DATA_W-1:0]    m_axis_tdata;

  header_parse_scoreboard sb;
  bit          quiet_tx;
  bit          quiet_rx;
  int unsigned n_sent;
  int unsigned idle_cycles;
  item_t       seen_item;
  result_t     seen_result;

  header_sync_message_parser u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_user),
    .s_axis_tdata  (s_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_ready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // transfer monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (s_valid && s_axis_tready) begin
        seen_item.cmd  = cmd_e'(s_user);
        seen_item.data = s_data;
        sb.note_input(seen_item);
      end
      if (m_axis_tvalid && m_ready) begin
        seen_result.status           = status_e'(m_axis_tuser[2:0]);
        seen_result.header_valid     = m_axis_tuser[3];
        seen_result.payload_valid    = m_axis_tuser[4];
        seen_result.payload_length   = m_axis_tdata[15:0];
        seen_result.reset_value      = m_axis_tdata[31:16];
        seen_result.sequence_number  = m_axis_tdata[47:32];
        seen_result.opcode_value     = m_axis_tdata[63:48];
        seen_result.payload_byte     = m_axis_tdata[71:64];
        seen_result.payload_position = m_axis_tdata[87:72];
        sb.check_result(seen_result);
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // result side: random stall before each transfer
  initial begin
    int unsigned stall;
    m_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk_i);
    forever begin
      stall = quiet_rx ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      @(negedge clk_i);
    end
  end

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input cmd_e cmd, input logic [7:0] data);
    int unsigned gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_noise();
    send_item(cmd_e'(2'($urandom_range(0, 3))), 8'($urandom));
  endtask

  // drain everything before touching the registers
  task automatic settle();
    s_valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] m1, input logic [7:0] m2,
                              input logic [7:0] m3, input logic [7:0] msum,
                              input logic [15:0] cap);
    logic [CFG_DATA_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0]  idxs [5];
    vals = '{16'(m1), 16'(m2), 16'(m3), 16'(msum), cap};
    idxs = '{REG_MAGIC_FIRST, REG_MAGIC_SECOND, REG_MAGIC_THIRD, REG_MAGIC_SUM,
             REG_BUFFER_CAPACITY};
    for (int i = 0; i < 5; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idxs[i];
      cfg_data <= vals[i];
      @(negedge clk_i);
      sb.write_reg(idxs[i], vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic send_header(input logic [15:0] len, input logic [15:0] rv,
                             input logic [15:0] seq, input logic [15:0] op,
                             input bit corrupt);
    logic [7:0] hdr [HEADER_BYTES];
    logic [7:0] parity;
    int unsigned pos;
    hdr[0]  = sb.regs.magic_first;
    hdr[1]  = sb.regs.magic_second;
    hdr[2]  = sb.regs.magic_third;
    hdr[4]  = len[7:0];
    hdr[5]  = len[15:8];
    hdr[6]  = rv[7:0];
    hdr[7]  = rv[15:8];
    hdr[8]  = seq[7:0];
    hdr[9]  = seq[15:8];
    hdr[10] = op[7:0];
    hdr[11] = op[15:8];
    parity = sb.regs.magic_sum;
    for (int k = 4; k < HEADER_BYTES; k++) parity += hdr[k];
    hdr[3] = ~parity;
    if (corrupt) begin
      pos = $urandom_range(0, HEADER_BYTES - 1);
      hdr[pos] ^= 8'(1 << $urandom_range(0, 7));
    end
    for (int k = 0; k < HEADER_BYTES; k++) send_item(CMD_DATA, hdr[k]);
  endtask

  // header, payload, then reopen; now and then oversized or cut short
  task automatic send_message();
    logic [15:0] cap;
    logic [15:0] len;
    int unsigned pick;
    int unsigned cut;
    cap = sb.regs.buffer_capacity;
    repeat ($urandom_range(0, 2)) send_item(CMD_DATA, 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 10) len = 16'd0;
    else if (pick < 80) len = 16'($urandom_range(1, 8));
    else if (pick < 92 || cap == 16'hFFFF) len = 16'($urandom_range(9, 40));
    else len = 16'($urandom_range(int'(cap) + 1, 65535));
    send_header(len, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
    if (len > cap) begin
      send_item(CMD_DATA, 8'($urandom));
      if (len > 16'd40) begin
        send_item(CMD_RESET, 8'($urandom));
        return;
      end
      // collection resumes from position zero after a restart
      send_item(CMD_START, 8'($urandom));
    end
    cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len;
    for (int k = 0; k < cut; k++) send_item(CMD_DATA, 8'($urandom));
    if (cut < len) begin
      send_item($urandom_range(0, 1) ? CMD_START : CMD_RESET, 8'($urandom));
      return;
    end
    if ($urandom_range(0, 3) == 0) send_item(CMD_DATA, 8'($urandom));
    send_item(($urandom_range(0, 4) == 0) ? CMD_RESET : CMD_START, 8'($urandom));
  endtask

  initial begin
    logic [7:0]  m1, m2, m3, msum;
    logic [15:0] cap;
    int unsigned phase_idx;
    int unsigned phase_start;
    int unsigned pick;
    sb          = new();
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_idx     = '0;
    cfg_data    = '0;
    s_valid     = 1'b0;
    s_user      = '0;
    s_data      = '0;
    quiet_tx    = 1'b0;
    quiet_rx    = 1'b0;
    n_sent      = 0;
    idle_cycles = 0;
    repeat (12) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    // defaults: zero magic bytes and seed, full capacity
    send_item(CMD_BAD, 8'hFF);
    send_header(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 1'b0);
    send_item(CMD_DATA, 8'h00);
    send_item(CMD_START, 8'h00);

    // zero capacity refuses both restart commands
    settle();
    program_regs(8'h00, 8'h00, 8'h00, 8'h00, 16'h0000);
    send_item(CMD_START, 8'hA5);
    send_item(CMD_RESET, 8'h5A);

    // largest length against a one-byte buffer, then escape by full reset
    settle();
    program_regs(8'hFF, 8'hFF, 8'hFF, 8'hFD, 16'd1);
    send_header(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 1'b0);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_RESET, 8'h00);

    phase_idx = 0;
    while (sb.useful_items < ITEM_TARGET) begin
      settle();
      case (phase_idx % 4)
        0: begin
          m1 = 8'hFF; m2 = 8'hFF; m3 = 8'hFF; cap = 16'hFFFF;
        end
        1: begin
          m1 = 8'h00; m2 = 8'h00; m3 = 8'h00; cap = 16'd1;
        end
        default: begin
          m1 = 8'($urandom); m2 = 8'($urandom); m3 = 8'($urandom);
          cap = $urandom_range(0, 2) ? 16'($urandom_range(1, 12)) : 16'hFFFF;
        end
      endcase
      msum = ($urandom_range(0, 3) != 0) ? 8'(m1 + m2 + m3) : 8'($urandom);
      program_regs(m1, m2, m3, msum, cap);
      quiet_tx = ($urandom_range(0, 3) == 0);
      quiet_rx = ($urandom_range(0, 3) == 0);
      phase_start = n_sent;
      while (n_sent - phase_start < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) send_message();
        else if (pick < 85)
          send_header(16'($urandom_range(0, 8)), 16'($urandom), 16'($urandom),
                      16'($urandom), 1'b1);
        else repeat ($urandom_range(1, 4)) send_noise();
      end
      phase_idx++;
    end

    settle();
    if (sb.n_errors == 0 && sb.expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
